[rtl/tti_pkg.sv]
// Shared widths, reset values, register indexes, codes and types of the thermistor interpolator.
package tti_pkg;

    localparam int DATA_W      = 32;
    localparam int SAMPLE_W    = 12;
    localparam int INDEX_W     = 5;
    localparam int COUNT_W     = 6;
    localparam int GAIN_W      = 31;
    localparam int OFFSET_W    = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 31;

    localparam int MAX_ENTRIES_DEFAULT = 32;

    localparam logic [COUNT_W-1:0]  ENTRY_COUNT_RESET = 6'd32;
    localparam logic [GAIN_W-1:0]   GAIN_RESET        = 31'd14198150;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET      = 24'd22872;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET      = 2'd2;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] res;
        logic signed [DATA_W-1:0] temp;
    } entry_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] r;
        logic signed [DATA_W-1:0] rp;
        logic signed [DATA_W-1:0] tp;
        logic signed [DATA_W-1:0] rc;
        logic signed [DATA_W-1:0] tc;
    } interp_op_t;

endpackage

[rtl/thermistor_table_interpolator.sv]
// Top level of the thermistor table interpolator: ports, config registers and scan sequencer.
//
//  channel   signals                                        handshake
//  -------   --------------------------------------------   ---------------------------
//  input     func entry_index entry_resistance              taken when start && !busy
//            entry_temperature adc_sample
//  result    temperature resistance past_table_end          valid one cycle with done
//  config    cfg_write_en cfg_index cfg_data                written when cfg_write_en
//
// A load item writes one table entry at the accepting edge. A convert item runs the
// bit-serial gain multiply (12 steps) and the one-entry-a-cycle table scan; when an entry
// matches, the interpolation unit adds its 33-step multiply and 35-step divide.
// Reset (rst_n low, asynchronous) restores the config registers; table contents are
// undefined until loaded. The result receiver cannot stall: done is a one-cycle strobe.
module thermistor_table_interpolator #(
    parameter int MAX_ENTRIES = tti_pkg::MAX_ENTRIES_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 func,
    input  logic [tti_pkg::INDEX_W-1:0]          entry_index,
    input  logic signed [tti_pkg::DATA_W-1:0]    entry_resistance,
    input  logic signed [tti_pkg::DATA_W-1:0]    entry_temperature,
    input  logic [tti_pkg::SAMPLE_W-1:0]         adc_sample,
    input  logic                                 cfg_write_en,
    input  logic [tti_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tti_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                 done,
    output logic signed [tti_pkg::DATA_W-1:0]    temperature,
    output logic signed [tti_pkg::DATA_W-1:0]    resistance,
    output logic                                 past_table_end
);
    import tti_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCALE  = 4'b0010,
        S_SCAN   = 4'b0100,
        S_INTERP = 4'b1000
    } state_t;

    // config registers
    logic [COUNT_W-1:0]  entry_count_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [OFFSET_W-1:0] offset_reg;

    // sequencer
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] n_clamp;
    logic             done_reg, done_next;

    // datapath
    logic signed [DATA_W-1:0] r_reg, r_next;
    entry_t                   prev_reg, prev_next;
    logic signed [DATA_W-1:0] tout_reg, tout_next;
    logic signed [DATA_W-1:0] rout_reg, rout_next;
    logic                     past_reg, past_next;

    logic                     accept;
    logic                     conv_accept;
    logic                     load_accept;
    logic                     table_wr;
    logic [ADDR_W+INDEX_W-1:0] wr_idx_ext;
    entry_t                   wr_entry;
    entry_t                   rd_data;
    logic                     match;

    logic                     scale_done;
    logic signed [DATA_W-1:0] scale_res;
    logic                     interp_start;
    logic                     interp_done;
    logic signed [DATA_W-1:0] interp_res;
    interp_op_t               interp_op;

    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && !busy;
    assign conv_accept = accept && (func == FUNC_CONVERT);
    assign load_accept = accept && (func == FUNC_LOAD);

    // loads beyond the store are dropped
    assign table_wr   = load_accept && (32'(entry_index) < MAX_ENTRIES);
    assign wr_idx_ext = (ADDR_W + INDEX_W)'(entry_index);
    assign wr_entry   = '{res: entry_resistance, temp: entry_temperature};

    // config writes; an index past the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= ENTRY_COUNT_RESET;
            gain_reg        <= GAIN_RESET;
            offset_reg      <= OFFSET_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_GAIN:        gain_reg        <= cfg_data[GAIN_W-1:0];
                CFG_OFFSET:      offset_reg      <= cfg_data[OFFSET_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // entry count: zero acts as one, above the store acts as the store size
    always_comb
    begin
        if (entry_count_reg == '0)
        begin
            n_clamp = CNT_W'(1);
        end
        else if (32'(entry_count_reg) > MAX_ENTRIES)
        begin
            n_clamp = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            n_clamp = CNT_W'(entry_count_reg);
        end
    end

    tti_table #(
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (table_wr),
        .wr_addr (wr_idx_ext[ADDR_W-1:0]),
        .wr_data (wr_entry),
        .rd_addr (idx_next[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    tti_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (conv_accept),
        .sample     (adc_sample),
        .gain       (gain_reg),
        .offset     (offset_reg),
        .done       (scale_done),
        .resistance (scale_res)
    );

    // read data always belongs to idx_reg: the address is idx_next, registered once
    assign match = ($signed(rd_data.res) < r_reg);

    assign interp_op = '{r: r_reg, rp: prev_reg.res, tp: prev_reg.temp,
                         rc: rd_data.res, tc: rd_data.temp};

    tti_interp u_interp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (interp_start),
        .op     (interp_op),
        .done   (interp_done),
        .result (interp_res)
    );

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        done_next    = 1'b0;
        r_next       = r_reg;
        prev_next    = prev_reg;
        tout_next    = tout_reg;
        rout_next    = rout_reg;
        past_next    = past_reg;
        interp_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (conv_accept)
                begin
                    state_next = S_SCALE;
                    idx_next   = '0;      // park the read on entry 0
                    n_next     = n_clamp;
                end
            end
            S_SCALE:
            begin
                if (scale_done)
                begin
                    r_next    = scale_res;
                    prev_next = rd_data;
                    if (n_reg == CNT_W'(1))
                    begin
                        // single entry: nothing to scan
                        tout_next  = rd_data.temp;
                        rout_next  = scale_res;
                        past_next  = 1'b1;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = CNT_W'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    interp_start = 1'b1;
                    state_next   = S_INTERP;
                end
                else if (idx_reg == n_reg - 1'b1)
                begin
                    // ran off the end: last entry's temperature
                    tout_next  = rd_data.temp;
                    rout_next  = r_reg;
                    past_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    prev_next = rd_data;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            S_INTERP:
            begin
                if (interp_done)
                begin
                    tout_next  = interp_res;
                    rout_next  = r_reg;
                    past_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            n_reg     <= CNT_W'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        prev_reg <= prev_next;
        tout_reg <= tout_next;
        rout_reg <= rout_next;
        past_reg <= past_next;
    end

    assign done           = done_reg;
    assign temperature    = tout_reg;
    assign resistance     = rout_reg;
    assign past_table_end = past_reg;

`ifndef NO_ASSERTIONS
    a_convert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_CONVERT) |=> busy)
        else $error("convert item did not start the sequencer");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_LOAD) |=> !done)
        else $error("load item produced a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe repeated");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (idx_reg < n_reg) && (idx_reg != '0))
        else $error("scan index out of range");
`endif

endmodule

[rtl/tti_table.sv]
// Table memory of (resistance, temperature) entries, one write and one registered read port.
module tti_table #(
    parameter int DEPTH = tti_pkg::MAX_ENTRIES_DEFAULT,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  tti_pkg::entry_t     wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output tti_pkg::entry_t     rd_data
);
    import tti_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/tti_scale.sv]
// Bit-serial sample scaling: resistance = ((sample * gain) >> 12) - offset.
module tti_scale (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [tti_pkg::SAMPLE_W-1:0]        sample,
    input  logic [tti_pkg::GAIN_W-1:0]          gain,
    input  logic [tti_pkg::OFFSET_W-1:0]        offset,
    output logic                                done,
    output logic signed [tti_pkg::DATA_W-1:0]   resistance
);
    import tti_pkg::*;

    localparam int STEP_W = $clog2(SAMPLE_W);

    logic                     run_reg;
    logic                     sub_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [GAIN_W-1:0]        acc_reg;
    logic [SAMPLE_W-1:0]      bits_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic [GAIN_W:0]          sum;

    // LSB first, shifting the partial sum right: the dropped bits are the >>12
    assign sum = {1'b0, acc_reg} + (bits_reg[0] ? {1'b0, gain} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SAMPLE_W - 1))
                begin
                    run_reg <= 1'b0;
                    sub_reg <= 1'b1;
                end
            end
            else if (sub_reg)
            begin
                sub_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= '0;
            bits_reg <= sample;
        end
        else if (run_reg)
        begin
            acc_reg  <= sum[GAIN_W:1];
            bits_reg <= bits_reg >> 1;
        end
        else if (sub_reg)
        begin
            res_reg <= $signed(DATA_W'(acc_reg) - DATA_W'(offset));
        end
    end

    assign done       = done_reg;
    assign resistance = res_reg;

endmodule

[rtl/tti_interp.sv]
// Serial interpolation unit: Tp + (R-Rp)*(Tc-Tp)/(Rc-Rp), shift-add multiply then restoring divide.
module tti_interp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  tti_pkg::interp_op_t                 op,
    output logic                                done,
    output logic signed [tti_pkg::DATA_W-1:0]   result
);
    import tti_pkg::*;

    localparam int OP_W  = DATA_W + 1;   // exact differences
    localparam int Q_W   = DATA_W + 3;   // quotient bits kept; clamp is 2^(Q_W-1)
    localparam int SUM_W = Q_W + 1;
    localparam int CNT_W = $clog2(Q_W + 1);
    localparam int LOW_W = Q_W - OP_W;
    localparam logic [Q_W-1:0] Q_LIMIT = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [5:0] {
        P_IDLE   = 6'b000001,
        P_ABS    = 6'b000010,
        P_MUL    = 6'b000100,
        P_DVINIT = 6'b001000,
        P_DIV    = 6'b010000,
        P_SUM    = 6'b100000
    } phase_t;

    phase_t                   phase_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     done_reg;
    logic [OP_W-1:0]          a_reg;     // dR, then |dR|
    logic [OP_W-1:0]          d_reg;     // dD, then |dD|
    logic [OP_W-1:0]          hi_reg;    // product high part, then remainder
    logic [Q_W-1:0]           lo_reg;    // dT / multiplier / quotient
    logic signed [DATA_W-1:0] tp_reg;
    logic                     neg_reg;
    logic signed [DATA_W-1:0] res_reg;

    logic [OP_W:0]   mul_sum;
    logic [OP_W:0]   div_t;
    logic [OP_W:0]   div_diff;
    logic            div_ge;
    logic [OP_W-1:0] rem_init;
    logic [Q_W-1:0]  q_clamped;
    logic [SUM_W-1:0] q_ext;
    logic [SUM_W-1:0] sum_full;
    logic signed [DATA_W-1:0] sum_sat;

    function automatic logic [OP_W-1:0] mag(input logic [OP_W-1:0] x);
        return x[OP_W-1] ? (~x + 1'b1) : x;
    endfunction

    assign mul_sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
    assign div_t    = {hi_reg, lo_reg[Q_W-1]};
    assign div_diff = div_t - {1'b0, d_reg};
    assign div_ge   = (div_t >= {1'b0, d_reg});
    assign rem_init = OP_W'(hi_reg[OP_W-1:LOW_W]);

    assign q_clamped = (lo_reg > Q_LIMIT) ? Q_LIMIT : lo_reg;
    assign q_ext     = {1'b0, q_clamped};
    assign sum_full  = {{(SUM_W-DATA_W){tp_reg[DATA_W-1]}}, tp_reg}
                     + (neg_reg ? (~q_ext + 1'b1) : q_ext);

    // saturate to the signed 32-bit range
    always_comb
    begin
        if (&sum_full[SUM_W-1:DATA_W-1] || ~|sum_full[SUM_W-1:DATA_W-1])
        begin
            sum_sat = $signed(sum_full[DATA_W-1:0]);
        end
        else if (sum_full[SUM_W-1])
        begin
            sum_sat = $signed({1'b1, {(DATA_W-1){1'b0}}});
        end
        else
        begin
            sum_sat = $signed({1'b0, {(DATA_W-1){1'b1}}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= P_ABS;
                    end
                end
                P_ABS:
                begin
                    cnt_reg <= '0;
                    if (d_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        phase_reg <= P_IDLE;
                    end
                    else
                    begin
                        phase_reg <= P_MUL;
                    end
                end
                P_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(OP_W - 1))
                    begin
                        phase_reg <= P_DVINIT;
                    end
                end
                P_DVINIT:
                begin
                    cnt_reg <= '0;
                    if (rem_init >= d_reg)
                    begin
                        phase_reg <= P_SUM;
                    end
                    else
                    begin
                        phase_reg <= P_DIV;
                    end
                end
                P_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(Q_W - 1))
                    begin
                        phase_reg <= P_SUM;
                    end
                end
                P_SUM:
                begin
                    done_reg  <= 1'b1;
                    phase_reg <= P_IDLE;
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    a_reg  <= {op.r[DATA_W-1], op.r} - {op.rp[DATA_W-1], op.rp};
                    d_reg  <= {op.rc[DATA_W-1], op.rc} - {op.rp[DATA_W-1], op.rp};
                    lo_reg <= Q_W'({op.tc[DATA_W-1], op.tc} - {op.tp[DATA_W-1], op.tp});
                    tp_reg <= op.tp;
                end
            end
            P_ABS:
            begin
                neg_reg <= a_reg[OP_W-1] ^ lo_reg[OP_W-1] ^ d_reg[OP_W-1];
                a_reg   <= mag(a_reg);
                d_reg   <= mag(d_reg);
                lo_reg  <= Q_W'(mag(lo_reg[OP_W-1:0]));
                hi_reg  <= '0;
                res_reg <= tp_reg;   // equal neighbors: earlier temperature
            end
            P_MUL:
            begin
                hi_reg <= mul_sum[OP_W:1];
                lo_reg <= {{LOW_W{1'b0}}, mul_sum[0], lo_reg[OP_W-1:1]};
            end
            P_DVINIT:
            begin
                if (rem_init >= d_reg)
                begin
                    lo_reg <= Q_LIMIT;   // quotient already past the clamp
                end
                else
                begin
                    hi_reg <= rem_init;
                    lo_reg <= {hi_reg[LOW_W-1:0], lo_reg[OP_W-1:0]};
                end
            end
            P_DIV:
            begin
                hi_reg <= div_ge ? div_diff[OP_W-1:0] : div_t[OP_W-1:0];
                lo_reg <= {lo_reg[Q_W-2:0], div_ge};
            end
            P_SUM:
            begin
                res_reg <= sum_sat;
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
